### sv/rth_pkg.sv
// Shared types and constants for the RGB to HSV/HSL converter.
package rth_pkg;

  localparam int unsigned QUO_W = 13;
  localparam int unsigned REM_W = 21;
  localparam int unsigned DIV_W = 9;
  localparam int unsigned HUE_W = 15;

  localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE = 15'd15360;
  localparam logic [REM_W-1:0] HUE_TWO_SIXTHS = 21'd7680;

  localparam logic MODE_HSV = 1'b0;
  localparam logic MODE_HSL = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [12:0] saturation;
    logic [7:0]  value_level;
    logic [8:0]  lightness_sum;
  } result_t;

  typedef struct packed {
    logic [HUE_W-1:0] base;
    logic             neg;
    logic             hue_zero;
    logic             sat_zero;
    logic [7:0]       value_level;
    logic [8:0]       lightness_sum;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem_h;
    logic [DIV_W-1:0] div_h;
    logic [QUO_W-1:0] quo_h;
    logic [REM_W-1:0] rem_s;
    logic [DIV_W-1:0] div_s;
    logic [QUO_W-1:0] quo_s;
    side_t            side;
  } work_t;

endpackage

### sv/rth_prep.sv
// Front end: channel extremes, hue sector and divider operands for one pixel.
module rth_prep (
  input  rth_pkg::pixel_t pix,
  input  logic            sat_mode,
  output rth_pkg::work_t  work
);
  import rth_pkg::*;

  logic [7:0] mx;
  logic [7:0] mn;
  logic [7:0] chroma;
  logic [8:0] sum;
  logic [7:0] diff;
  logic [7:0] den;

  always_comb begin
    mx = pix.red;
    mn = pix.red;
    if (pix.green > mx) mx = pix.green;
    if (pix.blue > mx) mx = pix.blue;
    if (pix.green < mn) mn = pix.green;
    if (pix.blue < mn) mn = pix.blue;
    chroma = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};

    work.side.neg = 1'b0;
    if (mx == pix.red) begin
      if (pix.green >= pix.blue) begin
        diff = pix.green - pix.blue;
        work.side.base = '0;
      end else begin
        diff = pix.blue - pix.green;
        work.side.base = HUE_FULL;
        work.side.neg = 1'b1;
      end
    end else if (mx == pix.green) begin
      work.side.base = HUE_GREEN;
      if (pix.blue >= pix.red) begin
        diff = pix.blue - pix.red;
      end else begin
        diff = pix.red - pix.blue;
        work.side.neg = 1'b1;
      end
    end else begin
      work.side.base = HUE_BLUE;
      if (pix.red >= pix.green) begin
        diff = pix.red - pix.green;
      end else begin
        diff = pix.green - pix.red;
        work.side.neg = 1'b1;
      end
    end

    if (sat_mode == MODE_HSL) begin
      den = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
    end else begin
      den = mx;
    end

    work.rem_h = REM_W'(diff) * HUE_TWO_SIXTHS + REM_W'(chroma);
    work.div_h = {chroma, 1'b0};
    work.quo_h = '0;
    work.rem_s = {chroma, 13'd0} + REM_W'(den);
    work.div_s = {den, 1'b0};
    work.quo_s = '0;
    work.side.hue_zero = (chroma == 8'd0);
    work.side.sat_zero = (den == 8'd0);
    work.side.value_level = mx;
    work.side.lightness_sum = sum;
  end

endmodule

### sv/rth_cell.sv
// One divider cell: a registered restoring step that settles one quotient bit of both divisions.
module rth_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid_in,
  input  rth_pkg::work_t work_in,
  output logic           ready_in,
  output logic           valid,
  output rth_pkg::work_t work,
  input  logic           ready_out
);
  import rth_pkg::*;

  localparam int unsigned WIDE_W = REM_W + DIV_W;

  logic [WIDE_W-1:0] step_h;
  logic [WIDE_W-1:0] step_s;
  work_t             work_next;

  always_comb begin
    step_h = WIDE_W'(work_in.div_h) << SHIFT;
    step_s = WIDE_W'(work_in.div_s) << SHIFT;
    work_next = work_in;
    if (WIDE_W'(work_in.rem_h) >= step_h) begin
      work_next.rem_h = work_in.rem_h - step_h[REM_W-1:0];
      work_next.quo_h[SHIFT] = 1'b1;
    end
    if (WIDE_W'(work_in.rem_s) >= step_s) begin
      work_next.rem_s = work_in.rem_s - step_s[REM_W-1:0];
      work_next.quo_s[SHIFT] = 1'b1;
    end
  end

  assign ready_in = !valid || ready_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_in) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      work <= work_next;
    end
  end

endmodule

### sv/rgb_to_hsv_hsl.sv
// RGB to HSV/HSL converter: input register, a chain of 13 divider cells and an output register.
// An accepted request passes through the input register, one cell per quotient bit and the output register.
// Throughput is one pixel per cycle while the output is not stalled; gaps in the chain close up while it is stalled.
// in_stall follows the chain's ready path from out_stall combinationally.
// Synchronous reset empties every stage and sets the saturation rule to HSV.
module rgb_to_hsv_hsl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  rth_pkg::pixel_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rth_pkg::result_t out_data,
  input  logic             cfg_write,
  input  logic             cfg_data
);
  import rth_pkg::*;

  logic                sat_mode;
  work_t               prep_work;
  logic                head_valid;
  work_t               head;
  logic                head_ready;
  logic [QUO_W:0]      chain_valid;
  work_t               chain_work [QUO_W+1];
  logic [QUO_W:0]      chain_ready;
  logic                out_ready;
  result_t             result_next;
  logic [HUE_W-1:0]    quo_hue;

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_mode <= MODE_HSV;
    end else if (cfg_write) begin
      sat_mode <= cfg_data;
    end
  end

  rth_prep u_prep (
    .pix      (in_data),
    .sat_mode (sat_mode),
    .work     (prep_work)
  );

  assign head_ready = !head_valid || chain_ready[0];
  assign in_stall = !head_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else if (head_ready) begin
      head_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (head_ready && in_valid) begin
      head <= prep_work;
    end
  end

  assign chain_valid[0] = head_valid;
  assign chain_work[0] = head;
  assign chain_ready[QUO_W] = out_ready;

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    rth_cell #(
      .SHIFT (QUO_W - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (chain_valid[k]),
      .work_in   (chain_work[k]),
      .ready_in  (chain_ready[k]),
      .valid     (chain_valid[k+1]),
      .work      (chain_work[k+1]),
      .ready_out (chain_ready[k+1])
    );
  end

  always_comb begin
    quo_hue = HUE_W'(chain_work[QUO_W].quo_h);
    if (chain_work[QUO_W].side.hue_zero) begin
      result_next.hue = '0;
    end else if (chain_work[QUO_W].side.neg) begin
      result_next.hue = chain_work[QUO_W].side.base - quo_hue;
    end else begin
      result_next.hue = chain_work[QUO_W].side.base + quo_hue;
    end
    result_next.saturation = chain_work[QUO_W].side.sat_zero ? '0 : chain_work[QUO_W].quo_s;
    result_next.value_level = chain_work[QUO_W].side.value_level;
    result_next.lightness_sum = chain_work[QUO_W].side.lightness_sum;
  end

  assign out_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= chain_valid[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && chain_valid[QUO_W]) begin
      out_data <= result_next;
    end
  end

endmodule

### tb/rth_checker.sv
// Checker for the RGB to HSV/HSL converter: predicts every accepted request and compares results.
`timescale 1ns / 1ps

module rth_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  rth_pkg::pixel_t  in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  rth_pkg::result_t out_data,
  input  logic             cfg_write,
  input  logic             cfg_data,
  output int               errors,
  output int               pending,
  output int               checked
);
  import rth_pkg::*;

  localparam int unsigned HUE_SIXTH = 3840;
  localparam int unsigned SAT_ONE = 4096;
  localparam int unsigned SPAN_FULL = 510;

  logic    sat_rule = MODE_HSV;
  result_t awaited_hsx[$];
  result_t want;
  int      fail_cnt = 0;
  int      match_cnt = 0;

  function automatic result_t convert_pixel(input pixel_t px, input logic rule);
    int unsigned r, g, b, hi, lo, chroma, span, num, hue, sat, den;
    result_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    chroma = hi - lo;
    span = hi + lo;
    hue = 0;
    sat = 0;
    if (chroma != 0) begin
      if (hi == r) begin
        if (g >= b) begin
          num = HUE_SIXTH * (g - b);
        end else begin
          num = HUE_FULL * chroma - HUE_SIXTH * (b - g);
        end
      end else if (hi == g) begin
        num = HUE_GREEN * chroma + HUE_SIXTH * b - HUE_SIXTH * r;
      end else begin
        num = HUE_BLUE * chroma + HUE_SIXTH * r - HUE_SIXTH * g;
      end
      hue = (2 * num + chroma) / (2 * chroma);
      if (hue >= HUE_FULL) hue = hue - HUE_FULL;
    end
    if (rule == MODE_HSV) begin
      if (hi != 0) sat = (2 * SAT_ONE * chroma + hi) / (2 * hi);
    end else if (span != 0 && span != SPAN_FULL) begin
      den = (span < SPAN_FULL - span) ? span : SPAN_FULL - span;
      sat = (2 * SAT_ONE * chroma + den) / (2 * den);
    end
    res.hue = hue[14:0];
    res.saturation = sat[12:0];
    res.value_level = hi[7:0];
    res.lightness_sum = span[8:0];
    return res;
  endfunction

  task automatic flag_field(input string field, input int exp_val, input int got_val);
    fail_cnt++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, got_val);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sat_rule <= MODE_HSV;
      awaited_hsx.delete();
    end else begin
      if (cfg_write) sat_rule <= cfg_data;
      if (in_valid && !in_stall) awaited_hsx.push_back(convert_pixel(in_data, sat_rule));
      if (out_valid && !out_stall) begin
        if (awaited_hsx.size() == 0) begin
          fail_cnt++;
          $display("%0t: result with no request waiting, expected none, got %h",
                   $time, out_data);
        end else begin
          want = awaited_hsx.pop_front();
          match_cnt++;
          if (out_data.hue !== want.hue)
            flag_field("hue", want.hue, out_data.hue);
          if (out_data.saturation !== want.saturation)
            flag_field("saturation", want.saturation, out_data.saturation);
          if (out_data.value_level !== want.value_level)
            flag_field("value_level", want.value_level, out_data.value_level);
          if (out_data.lightness_sum !== want.lightness_sum)
            flag_field("lightness_sum", want.lightness_sum, out_data.lightness_sum);
        end
      end
    end
    errors <= fail_cnt;
    checked <= match_cnt;
    pending <= awaited_hsx.size();
  end

endmodule

### tb/tb.sv
// Testbench top for the RGB to HSV/HSL converter: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb;
  import rth_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_REQUESTS = 250;
  localparam int CORNER_COUNT = 12;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_stall;
  pixel_t  in_data = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  result_t out_data;
  logic    cfg_write = 1'b0;
  logic    cfg_data = MODE_HSV;

  int errors;
  int pending;
  int checked;
  int sent_cnt = 0;
  int rule_writes = 0;
  int quiet_cycles = 0;

  int stall_level = 0;
  int level_left = 0;
  int run_left = 0;
  logic long_hit;

  logic [23:0] corner_rgb [CORNER_COUNT] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'h010000, 24'hFEFFFF
  };

  always #2 clk = ~clk;

  rgb_to_hsv_hsl u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  rth_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (level_left == 0) begin
        stall_level = $urandom_range(0, 3);
        level_left = $urandom_range(100, 400);
      end else begin
        level_left = level_left - 1;
      end
      if (run_left != 0) begin
        run_left = run_left - 1;
      end else begin
        case (stall_level)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 7) == 0);
          2: begin
            out_stall <= 1'($urandom_range(0, 1));
            run_left = $urandom_range(0, 3);
          end
          default: begin
            long_hit = ($urandom_range(0, 15) == 0);
            out_stall <= long_hit;
            run_left = long_hit ? $urandom_range(5, 20) : $urandom_range(0, 10);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_edge();
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      3: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    int base;
    int shade;
    px.red = 8'($urandom_range(0, 255));
    px.green = 8'($urandom_range(0, 255));
    px.blue = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      4: begin
        base = $urandom_range(0, 255);
        shade = base + $urandom_range(0, 6) - 3;
        px.red = 8'(base);
        px.green = (shade < 0) ? 8'd0 : (shade > 255) ? 8'd255 : 8'(shade);
        shade = base + $urandom_range(0, 6) - 3;
        px.blue = (shade < 0) ? 8'd0 : (shade > 255) ? 8'd255 : 8'(shade);
      end
      5: begin
        case ($urandom_range(0, 2))
          0: px.green = px.red;
          1: px.blue = px.green;
          default: px.red = px.blue;
        endcase
      end
      6: begin
        px.red = pick_edge();
        px.green = pick_edge();
        px.blue = pick_edge();
      end
      7: begin
        case ($urandom_range(0, 2))
          0: px.red = 8'd255;
          1: px.green = 8'd255;
          default: px.blue = 8'd255;
        endcase
        case ($urandom_range(0, 2))
          0: px.red = 8'd0;
          1: px.green = 8'd0;
          default: px.blue = 8'd0;
        endcase
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic send_pixel(input pixel_t px);
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_rule(input logic rule);
    cfg_write <= 1'b1;
    cfg_data <= rule;
    @(posedge clk);
    cfg_write <= 1'b0;
    rule_writes++;
  endtask

  task automatic stream_random(input int total, input int gap_style);
    int done;
    int burst;
    int gap;
    done = 0;
    while (done < total) begin
      burst = $urandom_range(1, 48);
      for (int i = 0; i < burst && done < total; i++) begin
        send_pixel(random_pixel());
        done++;
      end
      if ($urandom_range(0, 24) == 0) begin
        drain_all();
      end else begin
        case (gap_style)
          0: gap = 0;
          1: gap = $urandom_range(0, 3);
          default: gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 6);
        endcase
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_rule(MODE_HSV);
    for (int i = 0; i < CORNER_COUNT; i++) send_pixel(pixel_t'(corner_rgb[i]));
    drain_all();
    set_rule(MODE_HSL);
    for (int i = 0; i < CORNER_COUNT; i++) send_pixel(pixel_t'(corner_rgb[i]));
    drain_all();

    for (int phase = 0; phase < 6; phase++) begin
      set_rule((phase % 2 == 0) ? MODE_HSL : MODE_HSV);
      stream_random(PHASE_REQUESTS, (phase < 3) ? phase : 5 - phase);
      drain_all();
    end

    $display("Summary: %0d pixels sent (%0d corner cases), %0d results checked,",
             sent_cnt, 2 * CORNER_COUNT, checked);
    $display("         %0d saturation rule writes across HSV and HSL, with bursts and stalls.",
             rule_writes);
    if (pending != 0)
      $display("%0t: %0d expected results never arrived", $time, pending);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/rth_pkg.sv
sv/rth_prep.sv
sv/rth_cell.sv
sv/rgb_to_hsv_hsl.sv
tb/rth_checker.sv
tb/tb.sv
